FILE: rtl/core/mm_pkg.sv
`timescale 1ns / 1ps
// mm_pkg: sizes, codes, payload and command types for the matrix multiply block.
// Used by every module under rtl/core; depends on nothing.
package mm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam int FLD_IDX_W = 3;
	localparam int VAL_W     = 32;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int ACC_W     = PROD_W + IDX_W + 1;
	localparam int RND_BITS  = 16;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_BITS - 1);

	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_ROWS = 2'd0,
		REG_A_COLS = 2'd1,
		REG_B_ROWS = 2'd2,
		REG_B_COLS = 2'd3
	} mm_reg_t;

	typedef enum logic [1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_START  = 2'd2
	} mm_kind_t;

	typedef enum logic [1:0] {
		OP_LOAD_A,
		OP_LOAD_B,
		OP_RUN,
		OP_ERR
	} mm_op_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [FLD_IDX_W-1:0]    elem_row;
		logic [FLD_IDX_W-1:0]    elem_col;
		logic signed [VAL_W-1:0] elem_value;
	} mm_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] product_value;
		logic [FLD_IDX_W-1:0]    out_row;
		logic [FLD_IDX_W-1:0]    out_col;
		logic                    last_of_run;
		logic                    dim_error;
		logic                    overflow;
	} mm_out_t;

	typedef struct packed {
		logic [CFG_W-1:0] a_rows;
		logic [CFG_W-1:0] a_cols;
		logic [CFG_W-1:0] b_rows;
		logic [CFG_W-1:0] b_cols;
	} mm_cfg_t;

	// one queued command: a load, a run with its dimensions, or an error report
	typedef struct packed {
		mm_op_t                  op;
		logic [ADDR_W-1:0]       addr;
		logic signed [VAL_W-1:0] value;
		logic [DIM_W-1:0]        ar;
		logic [DIM_W-1:0]        ac;
		logic [DIM_W-1:0]        bc;
	} mm_cmd_t;

	// 0 counts as 1, anything above MAX_DIM counts as MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/mm_front.sv
`timescale 1ns / 1ps
// mm_front: takes input items, sorts them into load / run / error commands.
// Depends on mm_pkg.
module mm_front (
	input  logic            in_valid,
	output logic            in_ready,
	input  mm_pkg::mm_in_t  in_item,
	input  mm_pkg::mm_cfg_t cfg,
	input  logic            q_full,
	output logic            q_push,
	output mm_pkg::mm_cmd_t q_entry
);
	import mm_pkg::*;

	logic             in_range;
	logic [DIM_W-1:0] ac_eff;
	logic [DIM_W-1:0] br_eff;

	assign in_ready = !q_full;
	assign ac_eff   = eff_dim(cfg.a_cols);
	assign br_eff   = eff_dim(cfg.b_rows);
	assign in_range = (int'(in_item.elem_row) < MAX_DIM) && (int'(in_item.elem_col) < MAX_DIM);

	always_comb begin
		q_push        = 1'b0;
		q_entry       = '0;
		q_entry.addr  = {IDX_W'(in_item.elem_row), IDX_W'(in_item.elem_col)};
		q_entry.value = in_item.elem_value;
		q_entry.ar    = eff_dim(cfg.a_rows);
		q_entry.ac    = ac_eff;
		q_entry.bc    = eff_dim(cfg.b_cols);
		case (in_item.kind)
			KIND_LOAD_A: begin
				q_entry.op = OP_LOAD_A;
				q_push     = in_valid && !q_full && in_range;
			end
			KIND_LOAD_B: begin
				q_entry.op = OP_LOAD_B;
				q_push     = in_valid && !q_full && in_range;
			end
			KIND_START: begin
				q_entry.op = (ac_eff == br_eff) ? OP_RUN : OP_ERR;
				q_push     = in_valid && !q_full;
			end
			default: begin
				// unused kind: accepted and dropped
				q_push = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/mm_queue.sv
`timescale 1ns / 1ps
// mm_queue: short command FIFO between the front and the back.
// Depends on mm_pkg.
module mm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mm_pkg::mm_cmd_t entry_in,
	output logic            full,
	input  logic            pop,
	output mm_pkg::mm_cmd_t head,
	output logic            empty
);
	import mm_pkg::*;

	mm_cmd_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/mm_back.sv
`timescale 1ns / 1ps
// mm_back: element stores, one multiply-accumulate path and the result register.
// Depends on mm_pkg; fed by mm_queue.
module mm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  mm_pkg::mm_cmd_t q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output mm_pkg::mm_out_t out_item
);
	import mm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        n_q;
	logic [DIM_W-1:0]        ar_q;
	logic [DIM_W-1:0]        ac_q;
	logic [DIM_W-1:0]        bc_q;
	logic signed [ACC_W-1:0] acc_q;
	mm_out_t                 out_q;
	logic                    out_valid_q;

	logic signed [VAL_W-1:0] a_store_q [MEM_DEPTH];
	logic signed [VAL_W-1:0] b_store_q [MEM_DEPTH];

	logic signed [VAL_W-1:0]  a_rd_s1;
	logic signed [VAL_W-1:0]  b_rd_s1;
	logic                     v_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic                     last_s2;

	logic                    slot_free;
	logic                    issue;
	logic                    n_last;
	logic                    i_last;
	logic                    j_last;
	logic [ADDR_W-1:0]       a_raddr;
	logic [ADDR_W-1:0]       b_raddr;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] shifted;
	logic [ACC_W-VAL_W:0]    top_bits;
	logic                    sat;
	logic [VAL_W-1:0]        sat_val;
	mm_out_t                 res_item;
	mm_out_t                 err_item;

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == S_IDLE) && !q_empty && ((q_head.op != OP_ERR) || slot_free);
	assign issue     = (state_q == S_MAC);
	assign n_last    = (DIM_W'(n_q) == ac_q - DIM_W'(1));
	assign i_last    = (DIM_W'(i_q) == ar_q - DIM_W'(1));
	assign j_last    = (DIM_W'(j_q) == bc_q - DIM_W'(1));
	assign a_raddr   = {i_q, n_q};
	assign b_raddr   = {n_q, j_q};

	// round half up at bit 16, then clamp to the 32-bit range
	assign rnd      = acc_q + RND_HALF;
	assign shifted  = rnd >>> RND_BITS;
	assign top_bits = shifted[ACC_W-1:VAL_W-1];
	assign sat      = !((&top_bits) || (~|top_bits));
	assign sat_val  = sat ? (shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
	                                          : {1'b0, {(VAL_W-1){1'b1}}})
	                      : shifted[VAL_W-1:0];

	always_comb begin
		res_item               = '0;
		res_item.product_value = sat_val;
		res_item.out_row       = FLD_IDX_W'(i_q);
		res_item.out_col       = FLD_IDX_W'(j_q);
		res_item.last_of_run   = i_last && j_last;
		res_item.overflow      = sat;
		err_item               = '0;
		err_item.last_of_run   = 1'b1;
		err_item.dim_error     = 1'b1;
	end

	// stores and registered read ports
	always_ff @(posedge clk) begin
		if (q_pop && (q_head.op == OP_LOAD_A)) begin
			a_store_q[q_head.addr] <= q_head.value;
		end
		if (q_pop && (q_head.op == OP_LOAD_B)) begin
			b_store_q[q_head.addr] <= q_head.value;
		end
		a_rd_s1 <= a_store_q[a_raddr];
		b_rd_s1 <= b_store_q[b_raddr];
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && n_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			ar_q        <= '0;
			ac_q        <= '0;
			bc_q        <= '0;
			acc_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_head.op)
							OP_RUN: begin
								ar_q    <= q_head.ar;
								ac_q    <= q_head.ac;
								bc_q    <= q_head.bc;
								i_q     <= '0;
								j_q     <= '0;
								n_q     <= '0;
								acc_q   <= '0;
								state_q <= S_MAC;
							end
							OP_ERR: begin
								out_q       <= err_item;
								out_valid_q <= 1'b1;
							end
							default: begin
								// loads are written by the store block
							end
						endcase
					end
				end
				S_MAC: begin
					if (n_last) begin
						n_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						n_q <= n_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_q       <= res_item;
						out_valid_q <= 1'b1;
						if (i_last && j_last) begin
							state_q <= S_IDLE;
						end else begin
							if (j_last) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
							acc_q   <= '0;
							state_q <= S_MAC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef ASSERT_OFF
	a_prod_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_MAC || state_q == S_DRAIN))
		else $error("product in flight outside a run");
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (!v_s1 && !v_s2))
		else $error("element emitted before its sum was complete");
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (DIM_W'(n_q) < ac_q))
		else $error("inner index beyond a_cols");
	a_ij_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ((DIM_W'(i_q) < ar_q) && (DIM_W'(j_q) < bc_q)))
		else $error("element position outside the product");
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && !out_ready) |=> (state_q == S_EMIT))
		else $error("element dropped while result register busy");
`endif

endmodule

FILE: rtl/core/matrix_multiply.sv
`timescale 1ns / 1ps
// matrix_multiply: top level; config registers, front classifier, command queue, MAC back end.
// Depends on mm_pkg, mm_front, mm_queue, mm_back.
//
//  channel | signals                           | handshake
//  --------+-----------------------------------+---------------------------
//  input   | in_valid, in_ready, in_item       | valid/ready, item per beat
//  output  | out_valid, out_ready, out_item    | valid/ready, item per beat
//  config  | cfg_we, cfg_index, cfg_data       | write on cfg_we, no wait
//
// Loads are written into the stores as they are popped; an error start goes to the result register when popped.
// A run computes its elements one at a time, in row order:
// one multiply-accumulate path (store read, multiply, accumulate) serves every element.
// Reset clears the config registers to 8, the queue and the control state; stores keep junk.
// The two-entry queue lets loads and starts queue up while a run is busy; the result
// register holds one item so a stalled output does not stall the input until the queue fills.
module matrix_multiply (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mm_pkg::mm_in_t                in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mm_pkg::mm_out_t               out_item,
	input  logic                          cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]      cfg_data
);
	import mm_pkg::*;

	mm_cfg_t cfg_q;
	logic    q_push;
	logic    q_pop;
	logic    q_full;
	logic    q_empty;
	mm_cmd_t q_entry;
	mm_cmd_t q_head;

	// dimension registers; the user keeps them written only while idle, so no shadowing; enforcing that is up to the user
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_rows <= CFG_RESET;
			cfg_q.a_cols <= CFG_RESET;
			cfg_q.b_rows <= CFG_RESET;
			cfg_q.b_cols <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_ROWS: cfg_q.a_rows <= cfg_data;
				REG_A_COLS: cfg_q.a_cols <= cfg_data;
				REG_B_ROWS: cfg_q.b_rows <= cfg_data;
				REG_B_COLS: cfg_q.b_cols <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front: classify, clamp dimensions, check a_cols against b_rows
	mm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	mm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.entry_in (q_entry),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// back: stores, MAC sequencing, rounding and saturation, result register
	mm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
